FILE: rtl/core/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared types, constants and bucket lookup functions for the OHLC bar
// compressor.
// ----------------------------------------------------------------------------
package ohlc_pkg;

    localparam int SEC_W       = 17;   // second of day
    localparam int DOW_W       = 3;
    localparam int DOM_W       = 5;
    localparam int VOL_W       = 48;
    localparam int OI_W        = 32;
    localparam int LEN_W       = 4;
    localparam int SPAN_W      = 12;   // minute bucket span in seconds
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 17;
    localparam int QSEC_W      = 11;   // second / span, at most 1439
    localparam int REM_W       = 13;   // remainder estimate, below 2 * 3600
    localparam int RANGE_MIN_W = 28;   // holds +/-99999999

    localparam logic [SEC_W-1:0] SECS_PER_DAY = 17'd86400;
    localparam logic [SEC_W-1:0] LAST_SECOND  = 17'd86399;
    localparam logic [DOW_W-1:0] DOW_SUNDAY   = 3'd7;
    localparam logic [DOM_W-1:0] DAYS_PER_WEEK = 5'd7;

    localparam int RANGE_HIGH_RESET = -99999999;
    localparam int RANGE_LOW_RESET  = 99999999;

    typedef enum logic [LEN_W-1:0] {
        LEN_1M    = 4'd0,
        LEN_5M    = 4'd1,
        LEN_10M   = 4'd2,
        LEN_15M   = 4'd3,
        LEN_30M   = 4'd4,
        LEN_60M   = 4'd5,
        LEN_DAY   = 4'd6,
        LEN_WEEK  = 4'd7,
        LEN_MONTH = 4'd8
    } bar_len_t;

    function automatic logic is_minute(input bar_len_t len);
        logic r;
        unique case (len) inside
            [LEN_1M:LEN_60M]: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [SPAN_W-1:0] minute_span(input bar_len_t len);
        logic [SPAN_W-1:0] r;
        unique case (len)
            LEN_1M:  r = 12'd60;
            LEN_5M:  r = 12'd300;
            LEN_10M: r = 12'd600;
            LEN_15M: r = 12'd900;
            LEN_30M: r = 12'd1800;
            LEN_60M: r = 12'd3600;
            default: r = 12'd60;
        endcase
        return r;
    endfunction

    // floor(2^17 / span); quotient estimate is exact or one low
    function automatic logic [RECIP_W-1:0] minute_recip(input bar_len_t len);
        logic [RECIP_W-1:0] r;
        unique case (len)
            LEN_1M:  r = 12'd2184;
            LEN_5M:  r = 12'd436;
            LEN_10M: r = 12'd218;
            LEN_15M: r = 12'd145;
            LEN_30M: r = 12'd72;
            LEN_60M: r = 12'd36;
            default: r = 12'd2184;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/ohlc_if.sv
// ----------------------------------------------------------------------------
// ohlc channel interfaces
// Bar input channel, bar result channel and bar length write channel.
// ----------------------------------------------------------------------------
interface ohlc_bar_if
    import ohlc_pkg::*;
#(
    parameter int DAY_BITS   = 20,
    parameter int PRICE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic [DAY_BITS-1:0]          day_index;
    logic [SEC_W-1:0]             second_of_day;
    logic [DOW_W-1:0]             day_of_week;
    logic [DOM_W-1:0]             day_of_month;
    logic [DOM_W-1:0]             days_in_month;
    logic signed [PRICE_BITS-1:0] open_price;
    logic signed [PRICE_BITS-1:0] high_price;
    logic signed [PRICE_BITS-1:0] low_price;
    logic signed [PRICE_BITS-1:0] close_price;
    logic [VOL_W-1:0]             volume;
    logic [OI_W-1:0]              open_interest;
    logic                         flush;

    modport source (
        output valid, day_index, second_of_day, day_of_week, day_of_month,
               days_in_month, open_price, high_price, low_price, close_price,
               volume, open_interest, flush,
        input  ready
    );
    modport sink (
        input  valid, day_index, second_of_day, day_of_week, day_of_month,
               days_in_month, open_price, high_price, low_price, close_price,
               volume, open_interest, flush,
        output ready
    );
endinterface

interface ohlc_sum_if
    import ohlc_pkg::*;
#(
    parameter int DAY_BITS   = 20,
    parameter int PRICE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic [DAY_BITS-1:0]          out_day_index;
    logic [SEC_W-1:0]             out_second;
    logic signed [PRICE_BITS-1:0] out_open;
    logic signed [PRICE_BITS-1:0] out_high;
    logic signed [PRICE_BITS-1:0] out_low;
    logic signed [PRICE_BITS-1:0] out_close;
    logic [VOL_W-1:0]             out_volume;
    logic [OI_W-1:0]              out_open_interest;
    logic signed [PRICE_BITS-1:0] overall_high;
    logic signed [PRICE_BITS-1:0] overall_low;

    modport source (
        output valid, out_day_index, out_second, out_open, out_high, out_low,
               out_close, out_volume, out_open_interest, overall_high, overall_low,
        input  ready
    );
    modport sink (
        input  valid, out_day_index, out_second, out_open, out_high, out_low,
               out_close, out_volume, out_open_interest, overall_high, overall_low,
        output ready
    );
endinterface

interface ohlc_cfg_if
    import ohlc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] bar_length;

    modport source (output valid, bar_length, input ready);
    modport sink (input valid, bar_length, output ready);
endinterface

FILE: rtl/core/ohlc_front.sv
// ----------------------------------------------------------------------------
// ohlc_front
// Three-stage elastic pipeline: clamps the bar time, works out the time key
// and the bucket a bar would open, and hands a job to the queue.
// ----------------------------------------------------------------------------
module ohlc_front
    import ohlc_pkg::*;
#(
    parameter int DAY_BITS   = 20,
    parameter int PRICE_BITS = 32,
    localparam int KEY_W     = DAY_BITS + SEC_W,
    localparam int JOB_W     = 3 * KEY_W + DAY_BITS + SEC_W + 4 * PRICE_BITS
                               + VOL_W + OI_W + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    ohlc_bar_if.sink         bar,
    ohlc_cfg_if.sink         cfg,
    output logic             job_valid,
    input  logic             job_ready,
    output logic [JOB_W-1:0] job
);

    typedef struct packed {
        logic signed [PRICE_BITS-1:0] open;
        logic signed [PRICE_BITS-1:0] high;
        logic signed [PRICE_BITS-1:0] low;
        logic signed [PRICE_BITS-1:0] close;
        logic [VOL_W-1:0]             volume;
        logic [OI_W-1:0]              interest;
        logic                         flush;
    } pay_t;

    typedef struct packed {
        logic [KEY_W-1:0]             key;
        logic [KEY_W-1:0]             bstart;
        logic [KEY_W-1:0]             bend;
        logic [DAY_BITS-1:0]          day;
        logic [SEC_W-1:0]             second;
        pay_t                         pay;
    } job_t;

    // bar length register
    bar_len_t bar_len_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_len_reg <= LEN_DAY;
        end
        else if (cfg.valid)
        begin
            if (cfg.bar_length > LEN_MONTH)
                bar_len_reg <= LEN_DAY;
            else
                bar_len_reg <= bar_len_t'(cfg.bar_length);
        end
    end

    // elastic handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready  = !s3_valid_reg || job_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign bar.ready = s1_ready;
    assign job_valid = s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= bar.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // ---- stage 1 input logic ----
    logic [SEC_W-1:0]           sec_c;
    logic [SEC_W+RECIP_W-1:0]   qprod;
    logic [DOM_W-1:0]           back_days, span_days;
    logic [DAY_BITS-1:0]        back_c, start_day_c;
    logic [DAY_BITS:0]          end_day_c;
    pay_t                       pay_c;

    assign sec_c = (bar.second_of_day > LAST_SECOND) ? LAST_SECOND : bar.second_of_day;
    assign qprod = {{RECIP_W{1'b0}}, sec_c} * {{SEC_W{1'b0}}, minute_recip(bar_len_reg)};

    always_comb
    begin
        back_days = '0;
        span_days = DOM_W'(1);
        unique case (bar_len_reg)
            LEN_WEEK:
            begin
                // week runs Sunday..Saturday; Sunday and zero start a week
                back_days = (bar.day_of_week == DOW_SUNDAY) ? '0
                                                            : DOM_W'(bar.day_of_week);
                span_days = DAYS_PER_WEEK;
            end
            LEN_MONTH:
            begin
                back_days = (bar.day_of_month == '0) ? '0 : bar.day_of_month - 1'b1;
                span_days = (bar.days_in_month == '0) ? DOM_W'(1) : bar.days_in_month;
            end
            default:
            begin
                back_days = '0;
                span_days = DOM_W'(1);
            end
        endcase
    end

    // clamp a bucket start before day zero
    assign back_c      = (DAY_BITS'(back_days) > bar.day_index) ? bar.day_index
                                                                : DAY_BITS'(back_days);
    assign start_day_c = bar.day_index - back_c;
    assign end_day_c   = {1'b0, start_day_c} + (DAY_BITS + 1)'(span_days);

    assign pay_c.open     = bar.open_price;
    assign pay_c.high     = bar.high_price;
    assign pay_c.low      = bar.low_price;
    assign pay_c.close    = bar.close_price;
    assign pay_c.volume   = bar.volume;
    assign pay_c.interest = bar.open_interest;
    assign pay_c.flush    = bar.flush;

    logic [DAY_BITS-1:0] s1_day_reg, s1_start_day_reg;
    logic [DAY_BITS:0]   s1_end_day_reg;
    logic [SEC_W-1:0]    s1_sec_reg;
    logic                s1_minute_reg;
    logic [SPAN_W-1:0]   s1_span_reg;
    logic [QSEC_W-1:0]   s1_q_reg;
    pay_t                s1_pay_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready && bar.valid)
        begin
            s1_day_reg       <= bar.day_index;
            s1_sec_reg       <= sec_c;
            s1_minute_reg    <= is_minute(bar_len_reg);
            s1_span_reg      <= minute_span(bar_len_reg);
            s1_q_reg         <= qprod[RECIP_SHIFT +: QSEC_W];
            s1_start_day_reg <= start_day_c;
            s1_end_day_reg   <= end_day_c;
            s1_pay_reg       <= pay_c;
        end
    end

    // ---- stage 2: day base and calendar bucket products, remainder estimate ----
    logic [KEY_W-1:0] day_base_c, cal_start_c, cal_end_c;
    logic [SEC_W-1:0] qspan_c, rest_c;

    assign day_base_c  = KEY_W'(s1_day_reg) * KEY_W'(SECS_PER_DAY);
    assign cal_start_c = KEY_W'(s1_start_day_reg) * KEY_W'(SECS_PER_DAY);
    assign cal_end_c   = KEY_W'(s1_end_day_reg) * KEY_W'(SECS_PER_DAY);
    assign qspan_c     = SEC_W'(s1_q_reg) * SEC_W'(s1_span_reg);
    assign rest_c      = s1_sec_reg - qspan_c;

    logic [DAY_BITS-1:0] s2_day_reg;
    logic [SEC_W-1:0]    s2_sec_reg;
    logic                s2_minute_reg;
    logic [SPAN_W-1:0]   s2_span_reg;
    logic [REM_W-1:0]    s2_rem_reg;
    logic [KEY_W-1:0]    s2_base_reg, s2_cal_start_reg, s2_cal_end_reg;
    pay_t                s2_pay_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_day_reg       <= s1_day_reg;
            s2_sec_reg       <= s1_sec_reg;
            s2_minute_reg    <= s1_minute_reg;
            s2_span_reg      <= s1_span_reg;
            s2_rem_reg       <= rest_c[REM_W-1:0];
            s2_base_reg      <= day_base_c;
            s2_cal_start_reg <= cal_start_c;
            s2_cal_end_reg   <= cal_end_c;
            s2_pay_reg       <= s1_pay_reg;
        end
    end

    // ---- stage 3: finish the remainder and pick the bucket ----
    logic [REM_W-1:0] rem_c;
    logic [SEC_W-1:0] start_sec_c, end_sec_c;
    logic             rolls_c;
    job_t             job_c, s3_job_reg;

    assign rem_c       = (s2_rem_reg >= REM_W'(s2_span_reg)) ? s2_rem_reg - REM_W'(s2_span_reg)
                                                             : s2_rem_reg;
    assign start_sec_c = s2_sec_reg - SEC_W'(rem_c);
    assign end_sec_c   = start_sec_c + SEC_W'(s2_span_reg);
    assign rolls_c     = (end_sec_c == SECS_PER_DAY);

    always_comb
    begin
        job_c.key = s2_base_reg + KEY_W'(s2_sec_reg);
        job_c.pay = s2_pay_reg;
        if (s2_minute_reg)
        begin
            // minute bars are stamped with the bucket end
            job_c.bstart = s2_base_reg + KEY_W'(start_sec_c);
            job_c.bend   = s2_base_reg + KEY_W'(end_sec_c);
            job_c.day    = rolls_c ? s2_day_reg + 1'b1 : s2_day_reg;
            job_c.second = rolls_c ? '0 : end_sec_c;
        end
        else
        begin
            job_c.bstart = s2_cal_start_reg;
            job_c.bend   = s2_cal_end_reg;
            job_c.day    = s2_day_reg;
            job_c.second = s2_sec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
            s3_job_reg <= job_c;
    end

    assign job = s3_job_reg;

endmodule

FILE: rtl/core/ohlc_queue.sv
// ----------------------------------------------------------------------------
// ohlc_queue
// Two-entry queue between front and back; ready depends only on its count.
// ----------------------------------------------------------------------------
module ohlc_queue
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_data;
    end

endmodule

FILE: rtl/core/ohlc_back.sv
// ----------------------------------------------------------------------------
// ohlc_back
// Holds the pending bar: merges or emits per job, keeps the overall range,
// and drives the result register.
// ----------------------------------------------------------------------------
module ohlc_back
    import ohlc_pkg::*;
#(
    parameter int DAY_BITS   = 20,
    parameter int PRICE_BITS = 32,
    localparam int KEY_W     = DAY_BITS + SEC_W,
    localparam int JOB_W     = 3 * KEY_W + DAY_BITS + SEC_W + 4 * PRICE_BITS
                               + VOL_W + OI_W + 1,
    localparam int RANGE_W   = (PRICE_BITS > RANGE_MIN_W) ? PRICE_BITS : RANGE_MIN_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  logic [JOB_W-1:0] job,
    ohlc_sum_if.source       summary
);

    typedef struct packed {
        logic signed [PRICE_BITS-1:0] open;
        logic signed [PRICE_BITS-1:0] high;
        logic signed [PRICE_BITS-1:0] low;
        logic signed [PRICE_BITS-1:0] close;
        logic [VOL_W-1:0]             volume;
        logic [OI_W-1:0]              interest;
        logic                         flush;
    } pay_t;

    typedef struct packed {
        logic [KEY_W-1:0]             key;
        logic [KEY_W-1:0]             bstart;
        logic [KEY_W-1:0]             bend;
        logic [DAY_BITS-1:0]          day;
        logic [SEC_W-1:0]             second;
        pay_t                         pay;
    } job_t;

    job_t j;
    assign j = job;

    // pending bar
    logic                         pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0]             start_reg, start_next, end_reg, end_next;
    logic [DAY_BITS-1:0]          day_reg, day_next;
    logic [SEC_W-1:0]             sec_reg, sec_next;
    logic signed [PRICE_BITS-1:0] open_reg, open_next, high_reg, high_next;
    logic signed [PRICE_BITS-1:0] low_reg, low_next, close_reg, close_next;
    logic [VOL_W-1:0]             vol_reg, vol_next;
    logic [OI_W-1:0]              oi_reg, oi_next;
    // overall range, wide enough for its reset values
    logic signed [RANGE_W-1:0]    rhigh_reg, rhigh_next, rlow_reg, rlow_next;
    // result register
    logic                         sum_valid_reg, sum_valid_next;

    logic                         in_bucket, merge, emit, out_free, fire;
    logic [VOL_W:0]               vol_sum;
    logic signed [RANGE_W-1:0]    high_ext, low_ext;

    assign in_bucket = (j.key >= start_reg) && (j.key < end_reg);
    assign merge     = pend_valid_reg && !j.pay.flush && in_bucket;
    assign emit      = pend_valid_reg && !merge;
    assign out_free  = !sum_valid_reg || summary.ready;
    assign job_ready = !emit || out_free;
    assign fire      = job_valid && job_ready;

    assign vol_sum  = {1'b0, vol_reg} + {1'b0, j.pay.volume};
    assign high_ext = RANGE_W'(high_reg);
    assign low_ext  = RANGE_W'(low_reg);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        day_next        = day_reg;
        sec_next        = sec_reg;
        open_next       = open_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        close_next      = close_reg;
        vol_next        = vol_reg;
        oi_next         = oi_reg;
        rhigh_next      = rhigh_reg;
        rlow_next       = rlow_reg;
        sum_valid_next  = sum_valid_reg && !summary.ready;

        if (fire)
        begin
            if (j.pay.flush)
            begin
                pend_valid_next = 1'b0;
            end
            else if (merge)
            begin
                // bars arrive newest first: open is overwritten, close kept
                open_next = j.pay.open;
                if (j.pay.high > high_reg)
                    high_next = j.pay.high;
                if (j.pay.low < low_reg)
                    low_next = j.pay.low;
                vol_next = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];
                if (j.pay.interest > oi_reg)
                    oi_next = j.pay.interest;
            end
            else
            begin
                pend_valid_next = 1'b1;
                start_next      = j.bstart;
                end_next        = j.bend;
                day_next        = j.day;
                sec_next        = j.second;
                open_next       = j.pay.open;
                high_next       = j.pay.high;
                low_next        = j.pay.low;
                close_next      = j.pay.close;
                vol_next        = j.pay.volume;
                oi_next         = j.pay.interest;
            end

            if (emit)
            begin
                sum_valid_next = 1'b1;
                if (high_ext > rhigh_reg)
                    rhigh_next = high_ext;
                if (low_ext < rlow_reg)
                    rlow_next = low_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            rhigh_reg      <= RANGE_W'(RANGE_HIGH_RESET);
            rlow_reg       <= RANGE_W'(RANGE_LOW_RESET);
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            sum_valid_reg  <= sum_valid_next;
            rhigh_reg      <= rhigh_next;
            rlow_reg       <= rlow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        day_reg   <= day_next;
        sec_reg   <= sec_next;
        open_reg  <= open_next;
        high_reg  <= high_next;
        low_reg   <= low_next;
        close_reg <= close_next;
        vol_reg   <= vol_next;
        oi_reg    <= oi_next;
    end

    // result payload, loaded from the bar being emitted
    logic [DAY_BITS-1:0]          out_day_reg;
    logic [SEC_W-1:0]             out_sec_reg;
    logic signed [PRICE_BITS-1:0] out_open_reg, out_high_reg, out_low_reg, out_close_reg;
    logic signed [PRICE_BITS-1:0] out_rhigh_reg, out_rlow_reg;
    logic [VOL_W-1:0]             out_vol_reg;
    logic [OI_W-1:0]              out_oi_reg;

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_day_reg   <= day_reg;
            out_sec_reg   <= sec_reg;
            out_open_reg  <= open_reg;
            out_high_reg  <= high_reg;
            out_low_reg   <= low_reg;
            out_close_reg <= close_reg;
            out_vol_reg   <= vol_reg;
            out_oi_reg    <= oi_reg;
            out_rhigh_reg <= rhigh_next[PRICE_BITS-1:0];
            out_rlow_reg  <= rlow_next[PRICE_BITS-1:0];
        end
    end

    assign summary.valid             = sum_valid_reg;
    assign summary.out_day_index     = out_day_reg;
    assign summary.out_second        = out_sec_reg;
    assign summary.out_open          = out_open_reg;
    assign summary.out_high          = out_high_reg;
    assign summary.out_low           = out_low_reg;
    assign summary.out_close         = out_close_reg;
    assign summary.out_volume        = out_vol_reg;
    assign summary.out_open_interest = out_oi_reg;
    assign summary.overall_high      = out_rhigh_reg;
    assign summary.overall_low       = out_rlow_reg;

endmodule

FILE: rtl/core/ohlc_bar_compressor.sv
// ----------------------------------------------------------------------------
// ohlc_bar_compressor
// Merges a newest-first stream of price bars into 1..60 minute, daily,
// weekly or monthly bars and reports the running overall high and low.
// ----------------------------------------------------------------------------
// Usage: bars enter on "bar" newest first, one item per clock unless stalled.
// A bar inside the pending bucket is merged (earliest open, max high, min low,
// latest close, saturating volume sum, max open interest); a bar outside it,
// or a flush item, sends the pending bar out on "summary". A result passes
// through three front stages (time key and bucket bounds, with constant-divisor
// remainder math), a slot of the two-entry queue, then the back stage that owns
// the pending bar and the output register. The only loop is the back stage's
// combinational compare and registered update of the pending bar, so input
// ready drops only when the result side stalls and the queue fills. bar_length
// is written on "cfg" while the block is idle; codes above monthly are taken as
// daily. DAY_BITS and PRICE_BITS must match the channel interfaces' parameters.
// ----------------------------------------------------------------------------
module ohlc_bar_compressor
    import ohlc_pkg::*;
#(
    parameter int DAY_BITS   = 20,
    parameter int PRICE_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    ohlc_bar_if.sink   bar,
    ohlc_cfg_if.sink   cfg,
    ohlc_sum_if.source summary
);

    localparam int KEY_W = DAY_BITS + SEC_W;
    localparam int JOB_W = 3 * KEY_W + DAY_BITS + SEC_W + 4 * PRICE_BITS
                           + VOL_W + OI_W + 1;

    // front -> queue
    logic             fq_valid, fq_ready;
    logic [JOB_W-1:0] fq_job;
    // queue -> back
    logic             qb_valid, qb_ready;
    logic [JOB_W-1:0] qb_job;

    // front: config register, time key, candidate bucket
    ohlc_front #(
        .DAY_BITS   (DAY_BITS),
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bar       (bar),
        .cfg       (cfg),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // decoupling queue; its ready is registered-count based
    ohlc_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_job)
    );

    // back: pending bar, overall range, result register
    ohlc_back #(
        .DAY_BITS   (DAY_BITS),
        .PRICE_BITS (PRICE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .summary   (summary)
    );

endmodule

FILE: rtl/core/ohlc_checker.sv
// ----------------------------------------------------------------------------
// ohlc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ohlc_checker
#(
    parameter int PRICE_BITS = 32
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic signed [PRICE_BITS-1:0] out_high,
    input logic signed [PRICE_BITS-1:0] out_low,
    input logic signed [PRICE_BITS-1:0] out_close,
    input logic signed [PRICE_BITS-1:0] overall_high,
    input logic signed [PRICE_BITS-1:0] overall_low
);

    logic                         seen_reg;
    logic signed [PRICE_BITS-1:0] last_high_reg, last_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (res_valid && res_ready)
            seen_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            last_high_reg <= overall_high;
            last_low_reg  <= overall_low;
        end
    end

    // a stalled result stays valid and keeps its close price
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_close))
        else $error("result dropped or changed while stalled");

    // the overall range covers the bar being reported
    a_cover: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (overall_high >= out_high) && (overall_low <= out_low))
        else $error("overall range misses reported bar");

    // the overall range only widens from one result to the next
    a_widen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_reg |-> (overall_high >= last_high_reg)
                                  && (overall_low <= last_low_reg))
        else $error("overall range narrowed");

endmodule

bind ohlc_bar_compressor ohlc_checker #(
    .PRICE_BITS (PRICE_BITS)
) u_ohlc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (summary.valid),
    .res_ready    (summary.ready),
    .out_high     (summary.out_high),
    .out_low      (summary.out_low),
    .out_close    (summary.out_close),
    .overall_high (summary.overall_high),
    .overall_low  (summary.overall_low)
);
